@@ rtl/core/c8core_pkg.sv @@
// Shared constants, opcode codes and the hex font for the CHIP-8 instruction core.
package c8core_pkg;

  localparam int unsigned MEM_BYTES_DEF   = 4096;
  localparam int unsigned SCREEN_COLS_DEF = 64;
  localparam int unsigned SCREEN_ROWS_DEF = 32;
  localparam int unsigned STACK_SLOTS_DEF = 16;

  localparam logic [11:0] LOAD_BASE = 12'h200;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PIXEL = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_STACK  = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEQI = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SEQR = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GDLY = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDLY = 8'h15;
  localparam logic [7:0] MISC_SSND = 8'h18;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STOR = 8'h55;
  localparam logic [7:0] MISC_LOAD = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam logic [7:0] DEC_HUNDRED = 8'd100;
  localparam logic [7:0] DEC_TEN     = 8'd10;

  localparam int unsigned FONT_BYTES = 80;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Font byte at a glyph table offset; offsets past the table read zero.
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (32'(idx) < FONT_BYTES) begin
      b = FONT[idx];
    end
    return b;
  endfunction

endpackage

@@ rtl/core/c8core_ram.sv @@
// Generic single-port RAM with a registered read.
module c8core_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/chip8_instruction_core_unit.sv @@
// CHIP-8 instruction core: sequencer, register file, stack and both RAMs.
// An instruction is fetched, decoded and has its operands read before its own work:
// a clear walks every pixel, a sprite row visits each pixel with an extra step per lit
// pixel, BCD counts off hundreds then tens, and a register dump or load steps per register.
// Throughput is one word at a time; the next word is taken while a result still waits.
// After reset the main and frame RAMs are swept to load the font and blank the rest;
// no word is accepted during that sweep.
module chip8_instruction_core_unit
  import c8core_pkg::*;
#(
  parameter int unsigned MEM_BYTES   = c8core_pkg::MEM_BYTES_DEF,
  parameter int unsigned SCREEN_COLS = c8core_pkg::SCREEN_COLS_DEF,
  parameter int unsigned SCREEN_ROWS = c8core_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned STACK_SLOTS = c8core_pkg::STACK_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] program_counter_o,
  output logic [7:0]  read_value_o,
  output logic [7:0]  sound_level_o
);

  localparam int unsigned PIXELS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned CLR    = (MEM_BYTES > PIXELS) ? MEM_BYTES : PIXELS;
  localparam int unsigned AW     = $clog2(MEM_BYTES);
  localparam int unsigned PW     = $clog2(PIXELS);
  localparam int unsigned CNTW   = $clog2(CLR);
  localparam int unsigned SPW    = $clog2(STACK_SLOTS + 1);
  localparam int unsigned SIW    = $clog2(STACK_SLOTS);
  localparam int unsigned CXW    = $clog2(SCREEN_COLS) + 1;
  localparam int unsigned RYW    = $clog2(SCREEN_ROWS) + 1;

  // Sequencer states.
  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_MEMRD    = 5'd2;
  localparam logic [4:0] S_PIXRD    = 5'd3;
  localparam logic [4:0] S_FETCH_HI = 5'd4;
  localparam logic [4:0] S_FETCH_LO = 5'd5;
  localparam logic [4:0] S_DEC      = 5'd6;
  localparam logic [4:0] S_RDX      = 5'd7;
  localparam logic [4:0] S_RDY      = 5'd8;
  localparam logic [4:0] S_EXEC     = 5'd9;
  localparam logic [4:0] S_CLS      = 5'd10;
  localparam logic [4:0] S_SPR_ROW  = 5'd11;
  localparam logic [4:0] S_SPR_BYTE = 5'd12;
  localparam logic [4:0] S_SPR_PIX  = 5'd13;
  localparam logic [4:0] S_SPR_XOR  = 5'd14;
  localparam logic [4:0] S_SPR_END  = 5'd15;
  localparam logic [4:0] S_BCD_H    = 5'd16;
  localparam logic [4:0] S_BCD_T    = 5'd17;
  localparam logic [4:0] S_BCD_O    = 5'd18;
  localparam logic [4:0] S_STORE    = 5'd19;
  localparam logic [4:0] S_LD_RD    = 5'd20;
  localparam logic [4:0] S_LD_WR    = 5'd21;
  localparam logic [4:0] S_RESP     = 5'd22;

  // A 12-bit address folded into the main memory by at most four folds.
  function automatic logic [AW-1:0] mem_idx(input logic [11:0] a);
    logic [16:0] v;
    v = 17'(a);
    for (int k = 0; k < 4; k++) begin
      if (32'(v) >= MEM_BYTES) begin
        v = v - 17'(MEM_BYTES);
      end
    end
    return v[AW-1:0];
  endfunction

  // Sprite start column and row, taken modulo the screen size.
  function automatic logic [CXW-1:0] col_mod(input logic [7:0] a);
    logic [8:0] v;
    v = 9'(a);
    for (int k = 0; k < 4; k++) begin
      if (32'(v) >= SCREEN_COLS) begin
        v = v - 9'(SCREEN_COLS);
      end
    end
    return CXW'(v);
  endfunction

  function automatic logic [RYW-1:0] row_mod(input logic [7:0] a);
    logic [8:0] v;
    v = 9'(a);
    for (int k = 0; k < 8; k++) begin
      if (32'(v) >= SCREEN_ROWS) begin
        v = v - 9'(SCREEN_ROWS);
      end
    end
    return RYW'(v);
  endfunction

  // Control state.
  logic [4:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [11:0]     pc_q, pc_d;
  logic [11:0]     idx_q, idx_d;
  logic [SPW-1:0]  sp_q, sp_d;
  logic [7:0]      dly_q, dly_d;
  logic [7:0]      snd_q, snd_d;
  logic            out_valid_q, out_valid_d;
  logic [11:0]     stack_q [STACK_SLOTS];
  logic [7:0]      regs_q [16];

  // Working registers of the current word.
  logic [15:0]     op_q, op_d;
  logic [7:0]      hi_q, hi_d;
  logic [7:0]      vx_q, vx_d;
  logic [7:0]      vy_q, vy_d;
  logic [7:0]      rnd_q, rnd_d;
  logic [1:0]      st_q, st_d;
  logic [7:0]      rv_q, rv_d;
  logic [3:0]      row_q, row_d;
  logic [2:0]      col_q, col_d;
  logic [CXW-1:0]  sx_q, sx_d;
  logic [RYW-1:0]  sy_q, sy_d;
  logic [7:0]      byte_q, byte_d;
  logic            hit_q, hit_d;
  logic [7:0]      acc_q, acc_d;
  logic [3:0]      dig_q, dig_d;
  logic [1:0]      ost_q, ost_d;
  logic [11:0]     opc_q, opc_d;
  logic [7:0]      orv_q, orv_d;
  logic [7:0]      osnd_q, osnd_d;

  // Register file, stack and RAM write strobes.
  logic            rf_we, vf_we, stk_we;
  logic [3:0]      rf_wa, rsel;
  logic [7:0]      rf_wd, rdat;
  logic            vf_wd;
  logic [11:0]     stk_wd;
  logic [SIW-1:0]  stk_wa;
  logic            m_we, f_we;
  logic [AW-1:0]   m_addr;
  logic [7:0]      m_wd, m_rd;
  logic [PW-1:0]   f_addr;
  logic            f_wd, f_rd;

  logic [3:0]      op_x, op_y, op_n;
  logic [7:0]      op_kk;
  logic [11:0]     op_nnn, pc_n;
  logic [8:0]      sum9;
  logic [SPW-1:0]  sp_m1;
  logic [CXW-1:0]  cpos;
  logic [RYW-1:0]  rpos;
  logic [PW-1:0]   ppos;
  logic            adv;

  assign op_x   = op_q[11:8];
  assign op_y   = op_q[7:4];
  assign op_n   = op_q[3:0];
  assign op_kk  = op_q[7:0];
  assign op_nnn = op_q[11:0];
  assign pc_n   = pc_q + 12'd2;
  assign sum9   = {1'b0, vx_q} + {1'b0, vy_q};
  assign sp_m1  = sp_q - SPW'(1);

  // One read port on the register file; the sequencer chooses the entry.
  always_comb begin
    case (state_q)
      S_RDX:   rsel = (op_q[15:12] == GRP_JPV0) ? 4'h0 : op_x;
      S_RDY:   rsel = op_y;
      S_STORE: rsel = cnt_q[3:0];
      default: rsel = 4'h0;
    endcase
  end
  assign rdat = regs_q[rsel];

  // Pixel position of the current sprite bit, wrapped at the screen edges.
  always_comb begin
    cpos = sx_q + CXW'(col_q);
    if (32'(cpos) >= SCREEN_COLS) begin
      cpos = cpos - CXW'(SCREEN_COLS);
    end
    rpos = sy_q + RYW'(row_q);
    if (32'(rpos) >= SCREEN_ROWS) begin
      rpos = rpos - RYW'(SCREEN_ROWS);
    end
    ppos = PW'(rpos) * PW'(SCREEN_COLS) + PW'(cpos);
  end

  c8core_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .addr_i  (m_addr),
    .wdata_i (m_wd),
    .rdata_o (m_rd)
  );

  c8core_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .addr_i  (f_addr),
    .wdata_i (f_wd),
    .rdata_o (f_rd)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;   cnt_d = cnt_q;   pc_d = pc_q;   idx_d = idx_q;
    sp_d = sp_q;         dly_d = dly_q;   snd_d = snd_q;
    op_d = op_q;         hi_d = hi_q;     vx_d = vx_q;   vy_d = vy_q;
    rnd_d = rnd_q;       st_d = st_q;     rv_d = rv_q;
    row_d = row_q;       col_d = col_q;   sx_d = sx_q;   sy_d = sy_q;
    byte_d = byte_q;     hit_d = hit_q;   acc_d = acc_q; dig_d = dig_q;
    ost_d = ost_q;       opc_d = opc_q;   orv_d = orv_q; osnd_d = osnd_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    rf_we = 1'b0;  rf_wa = op_x;  rf_wd = 8'd0;
    vf_we = 1'b0;  vf_wd = 1'b0;
    stk_we = 1'b0; stk_wa = sp_q[SIW-1:0]; stk_wd = pc_n;
    m_we = 1'b0;   m_addr = mem_idx(pc_q); m_wd = 8'd0;
    f_we = 1'b0;   f_addr = ppos;          f_wd = 1'b0;
    adv = 1'b0;

    case (state_q)
      S_CLEAR: begin
        // Font in the low bytes, zero elsewhere; the frame is blanked alongside.
        m_we   = (32'(cnt_q) < MEM_BYTES);
        m_addr = cnt_q[AW-1:0];
        m_wd   = (32'(cnt_q) < FONT_BYTES) ? font_byte(cnt_q[6:0]) : 8'd0;
        f_we   = (32'(cnt_q) < PIXELS);
        f_addr = cnt_q[PW-1:0];
        if (cnt_q == CNTW'(CLR - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          st_d  = ST_OK;
          rv_d  = 8'd0;
          rnd_d = random_byte_i;
          case (command_i)
            CMD_WRITE: begin
              m_we    = 1'b1;
              m_addr  = mem_idx(address_i);
              m_wd    = write_data_i;
              state_d = S_RESP;
            end
            CMD_EXEC: begin
              state_d = S_FETCH_HI;
            end
            CMD_READ: begin
              m_addr  = mem_idx(address_i);
              state_d = S_MEMRD;
            end
            default: begin
              // Pixel read; indexes past the screen read zero.
              if (32'(address_i) < PIXELS) begin
                f_addr  = PW'(address_i);
                state_d = S_PIXRD;
              end else begin
                state_d = S_RESP;
              end
            end
          endcase
        end
      end
      S_MEMRD: begin
        rv_d    = m_rd;
        state_d = S_RESP;
      end
      S_PIXRD: begin
        rv_d    = {7'd0, f_rd};
        state_d = S_RESP;
      end
      S_FETCH_HI: begin
        m_addr  = mem_idx(pc_q);
        state_d = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        hi_d    = m_rd;
        m_addr  = mem_idx(pc_q + 12'd1);
        state_d = S_DEC;
      end
      S_DEC: begin
        op_d    = {hi_q, m_rd};
        state_d = S_RDX;
      end
      S_RDX: begin
        vx_d    = rdat;
        state_d = S_RDY;
      end
      S_RDY: begin
        vy_d    = rdat;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        pc_d    = pc_n;
        state_d = S_RESP;
        case (op_q[15:12])
          GRP_SYS: begin
            if (op_kk == SYS_CLS) begin
              cnt_d   = '0;
              state_d = S_CLS;
            end else if (op_kk == SYS_RET) begin
              if (sp_q == '0) begin
                st_d = ST_STACK;
              end else begin
                sp_d = sp_m1;
                pc_d = stack_q[sp_m1[SIW-1:0]];
              end
            end
          end
          GRP_JP: pc_d = op_nnn;
          GRP_CALL: begin
            if (32'(sp_q) >= STACK_SLOTS) begin
              st_d = ST_STACK;
            end else begin
              stk_we = 1'b1;
              sp_d   = sp_q + SPW'(1);
              pc_d   = op_nnn;
            end
          end
          GRP_SEQI: if (vx_q == op_kk) pc_d = pc_q + 12'd4;
          GRP_SNEI: if (vx_q != op_kk) pc_d = pc_q + 12'd4;
          GRP_SEQR: if (vx_q == vy_q)  pc_d = pc_q + 12'd4;
          GRP_SNER: if (vx_q != vy_q)  pc_d = pc_q + 12'd4;
          GRP_LDI: begin
            rf_we = 1'b1;
            rf_wd = op_kk;
          end
          GRP_ADDI: begin
            rf_we = 1'b1;
            rf_wd = vx_q + op_kk;
          end
          GRP_ALU: begin
            rf_we = 1'b1;
            case (op_n)
              ALU_MOV: rf_wd = vy_q;
              ALU_OR:  rf_wd = vx_q | vy_q;
              ALU_AND: rf_wd = vx_q & vy_q;
              ALU_XOR: rf_wd = vx_q ^ vy_q;
              ALU_ADD: begin
                rf_wd = sum9[7:0];
                vf_we = 1'b1;
                vf_wd = sum9[8];
              end
              ALU_SUB: begin
                rf_wd = vx_q - vy_q;
                vf_we = 1'b1;
                vf_wd = (vx_q >= vy_q);
              end
              ALU_SHR: begin
                rf_wd = {1'b0, vx_q[7:1]};
                vf_we = 1'b1;
                vf_wd = vx_q[0];
              end
              ALU_SBN: begin
                rf_wd = vy_q - vx_q;
                vf_we = 1'b1;
                vf_wd = (vy_q >= vx_q);
              end
              ALU_SHL: begin
                rf_wd = {vx_q[6:0], 1'b0};
                vf_we = 1'b1;
                vf_wd = vx_q[7];
              end
              default: begin
                rf_we = 1'b0;
                st_d  = ST_BAD_OP;
              end
            endcase
          end
          GRP_LDIX: idx_d = op_nnn;
          GRP_JPV0: pc_d = op_nnn + 12'(vx_q);
          GRP_RND: begin
            rf_we = 1'b1;
            rf_wd = rnd_q & op_kk;
          end
          GRP_DRW: begin
            sx_d  = col_mod(vx_q);
            sy_d  = row_mod(vy_q);
            row_d = 4'd0;
            hit_d = 1'b0;
            state_d = (op_n == 4'd0) ? S_SPR_END : S_SPR_ROW;
          end
          GRP_KEY: begin
            if (op_kk != KEY_SKP && op_kk != KEY_SKNP) begin
              st_d = ST_BAD_OP;
            end
          end
          default: begin
            case (op_kk)
              MISC_GDLY: begin
                rf_we = 1'b1;
                rf_wd = dly_q;
              end
              MISC_WKEY: st_d = ST_OK;
              MISC_SDLY: dly_d = vx_q;
              MISC_SSND: snd_d = vx_q;
              MISC_ADDI: idx_d = idx_q + 12'(vx_q);
              MISC_FONT: idx_d = {2'b00, vx_q, 2'b00} + 12'(vx_q);
              MISC_BCD: begin
                acc_d   = vx_q;
                dig_d   = 4'd0;
                state_d = S_BCD_H;
              end
              MISC_STOR: begin
                cnt_d   = '0;
                state_d = S_STORE;
              end
              MISC_LOAD: begin
                cnt_d   = '0;
                state_d = S_LD_RD;
              end
              default: st_d = ST_BAD_OP;
            endcase
          end
        endcase
      end
      S_CLS: begin
        f_we   = 1'b1;
        f_addr = cnt_q[PW-1:0];
        if (cnt_q == CNTW'(PIXELS - 1)) begin
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_SPR_ROW: begin
        m_addr  = mem_idx(idx_q + 12'(row_q));
        state_d = S_SPR_BYTE;
      end
      S_SPR_BYTE: begin
        byte_d  = m_rd;
        col_d   = 3'd0;
        state_d = S_SPR_PIX;
      end
      S_SPR_PIX: begin
        // The sprite byte shifts out MSB first, one pixel per visit.
        byte_d = {byte_q[6:0], 1'b0};
        if (byte_q[7]) begin
          state_d = S_SPR_XOR;
        end else begin
          adv = 1'b1;
        end
      end
      S_SPR_XOR: begin
        f_we  = 1'b1;
        f_wd  = ~f_rd;
        hit_d = hit_q | f_rd;
        adv   = 1'b1;
      end
      S_SPR_END: begin
        vf_we   = 1'b1;
        vf_wd   = hit_q;
        state_d = S_RESP;
      end
      S_BCD_H: begin
        if (acc_q >= DEC_HUNDRED) begin
          acc_d = acc_q - DEC_HUNDRED;
          dig_d = dig_q + 4'd1;
        end else begin
          m_we    = 1'b1;
          m_addr  = mem_idx(idx_q);
          m_wd    = {4'd0, dig_q};
          dig_d   = 4'd0;
          state_d = S_BCD_T;
        end
      end
      S_BCD_T: begin
        if (acc_q >= DEC_TEN) begin
          acc_d = acc_q - DEC_TEN;
          dig_d = dig_q + 4'd1;
        end else begin
          m_we    = 1'b1;
          m_addr  = mem_idx(idx_q + 12'd1);
          m_wd    = {4'd0, dig_q};
          state_d = S_BCD_O;
        end
      end
      S_BCD_O: begin
        m_we    = 1'b1;
        m_addr  = mem_idx(idx_q + 12'd2);
        m_wd    = acc_q;
        state_d = S_RESP;
      end
      S_STORE: begin
        m_we   = 1'b1;
        m_addr = mem_idx(idx_q + 12'(cnt_q[3:0]));
        m_wd   = rdat;
        if (cnt_q[3:0] == op_x) begin
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_LD_RD: begin
        m_addr  = mem_idx(idx_q + 12'(cnt_q[3:0]));
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        rf_we = 1'b1;
        rf_wa = cnt_q[3:0];
        rf_wd = m_rd;
        if (cnt_q[3:0] == op_x) begin
          state_d = S_RESP;
        end else begin
          cnt_d   = cnt_q + CNTW'(1);
          state_d = S_LD_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          ost_d       = st_q;
          opc_d       = pc_q;
          orv_d       = rv_q;
          osnd_d      = snd_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Step to the next sprite pixel, then the next row.
    if (adv) begin
      if (col_q == 3'd7) begin
        if (row_q == op_n - 4'd1) begin
          state_d = S_SPR_END;
        end else begin
          row_d   = row_q + 4'd1;
          state_d = S_SPR_ROW;
        end
      end else begin
        col_d   = col_q + 3'd1;
        state_d = S_SPR_PIX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pc_q        <= LOAD_BASE;
      idx_q       <= 12'd0;
      sp_q        <= '0;
      dly_q       <= 8'd0;
      snd_q       <= 8'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STACK_SLOTS; k++) begin
        stack_q[k] <= 12'd0;
      end
      for (int k = 0; k < 16; k++) begin
        regs_q[k] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      sp_q        <= sp_d;
      dly_q       <= dly_d;
      snd_q       <= snd_d;
      out_valid_q <= out_valid_d;
      if (stk_we) begin
        stack_q[stk_wa] <= stk_wd;
      end
      // The flag wins when the target is VF, so the plain write steps aside then.
      if (rf_we && !(vf_we && rf_wa == REG_VF)) begin
        regs_q[rf_wa] <= rf_wd;
      end
      if (vf_we) begin
        regs_q[REG_VF] <= {7'd0, vf_wd};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;   hi_q   <= hi_d;   vx_q  <= vx_d;  vy_q  <= vy_d;
    rnd_q  <= rnd_d;  st_q   <= st_d;   rv_q  <= rv_d;
    row_q  <= row_d;  col_q  <= col_d;  sx_q  <= sx_d;  sy_q  <= sy_d;
    byte_q <= byte_d; hit_q  <= hit_d;  acc_q <= acc_d; dig_q <= dig_d;
    ost_q  <= ost_d;  opc_q  <= opc_d;  orv_q <= orv_d; osnd_q <= osnd_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = ost_q;
  assign program_counter_o = opc_q;
  assign read_value_o      = orv_q;
  assign sound_level_o     = osnd_q;

endmodule

@@ rtl/core/c8core_checker.sv @@
// Port-level checks for the CHIP-8 instruction core, bound to the top level.
module c8core_checker
  import c8core_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  command_i,
  input logic [11:0] address_i,
  input logic [7:0]  write_data_i,
  input logic [7:0]  random_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [11:0] program_counter_o,
  input logic [7:0]  read_value_o,
  input logic [7:0]  sound_level_o
);

  logic unused_in;
  assign unused_in = ^{command_i, address_i, write_data_i, random_byte_i};

  // A result word that is not taken holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(program_counter_o) && $stable(read_value_o) && $stable(sound_level_o))
    else $error("result word changed while stalled");

  // Status never carries the unused code while a result is valid.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != ST_UNUSED)
    else $error("unused status code on output");

  // The core is busy in the cycle after taking a word.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accept");

  // A new result is loaded only from a busy cycle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the core was idle");

endmodule

bind chip8_instruction_core_unit c8core_checker u_c8core_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the CHIP-8 instruction core: directed tests and a random run.
module testbench;
  import c8core_pkg::*;

  // Watchdog limit in cycles with no word moving on either channel, set well above
  // the reset sweep and a screen clear.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PIXELS = SCREEN_COLS_DEF * SCREEN_ROWS_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] pc;
    logic [7:0]  value;
    logic [7:0]  sound;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic [7:0]  random_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [11:0] program_counter;
  logic [7:0]  read_value;
  logic [7:0]  sound_level;

  chip8_instruction_core_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .address_i        (address),
    .write_data_i     (write_data),
    .random_byte_i    (random_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .program_counter_o(program_counter),
    .read_value_o     (read_value),
    .sound_level_o    (sound_level)
  );

  // Shadow copy of the core's architectural state.
  logic [7:0]  ram_img [4096];
  logic [7:0]  vreg [16];
  logic [11:0] idx_img;
  logic [11:0] pc_img;
  int          sp_img;
  logic [11:0] stack_img [16];
  bit          frame_img [PIXELS];
  logic [7:0]  delay_img;
  logic [7:0]  sound_img;

  result_t pending_results [$];
  int      errors;
  int      words_sent;
  int      exec_count;
  int      stack_faults;
  int      bad_opcodes;
  int      results_seen;
  bit      no_gaps;
  int      idle_cycles;
  int      stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_image();
    for (int i = 0; i < 4096; i++) begin
      ram_img[i] = (i < FONT_BYTES) ? FONT[i] : 8'd0;
    end
    for (int i = 0; i < 16; i++) begin
      vreg[i] = 8'd0;
      stack_img[i] = 12'd0;
    end
    for (int i = 0; i < PIXELS; i++) begin
      frame_img[i] = 1'b0;
    end
    idx_img = 12'd0;
    pc_img = LOAD_BASE;
    sp_img = 0;
    delay_img = 8'd0;
    sound_img = 8'd0;
  endfunction

  // Fetches the instruction at the program counter, updates the shadow state and
  // returns the status that the core must report.
  function automatic logic [1:0] exec_instruction(input logic [7:0] rnd);
    logic [15:0] op;
    logic [11:0] nnn;
    logic [7:0]  kk;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  row;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    int          sx;
    int          sy;
    int          pos;
    bit          hit;
    op  = {ram_img[pc_img], ram_img[pc_img + 12'd1]};
    nnn = op[11:0];
    kk  = op[7:0];
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    vx  = vreg[x];
    vy  = vreg[y];
    pc_img = pc_img + 12'd2;
    case (op[15:12])
      GRP_SYS: begin
        if (kk == SYS_CLS) begin
          for (int i = 0; i < PIXELS; i++) frame_img[i] = 1'b0;
        end else if (kk == SYS_RET) begin
          if (sp_img == 0) return ST_STACK;
          sp_img--;
          pc_img = stack_img[sp_img];
        end
      end
      GRP_JP: pc_img = nnn;
      GRP_CALL: begin
        if (sp_img >= STACK_SLOTS_DEF) return ST_STACK;
        stack_img[sp_img] = pc_img;
        sp_img++;
        pc_img = nnn;
      end
      GRP_SEQI: if (vx == kk) pc_img = pc_img + 12'd2;
      GRP_SNEI: if (vx != kk) pc_img = pc_img + 12'd2;
      GRP_SEQR: if (vx == vy) pc_img = pc_img + 12'd2;
      GRP_LDI:  vreg[x] = kk;
      GRP_ADDI: vreg[x] = vx + kk;
      GRP_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin
            vreg[x] = vx + vy;
            vreg[REG_VF] = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
          end
          ALU_SUB: begin
            vreg[x] = vx - vy;
            vreg[REG_VF] = (vx >= vy) ? 8'd1 : 8'd0;
          end
          ALU_SHR: begin
            vreg[x] = vx >> 1;
            vreg[REG_VF] = {7'd0, vx[0]};
          end
          ALU_SBN: begin
            vreg[x] = vy - vx;
            vreg[REG_VF] = (vy >= vx) ? 8'd1 : 8'd0;
          end
          ALU_SHL: begin
            vreg[x] = vx << 1;
            vreg[REG_VF] = {7'd0, vx[7]};
          end
          default: return ST_BAD_OP;
        endcase
      end
      GRP_SNER: if (vx != vy) pc_img = pc_img + 12'd2;
      GRP_LDIX: idx_img = nnn;
      GRP_JPV0: pc_img = nnn + {4'd0, vreg[0]};
      GRP_RND:  vreg[x] = rnd & kk;
      GRP_DRW: begin
        // The start point wraps onto the screen and every pixel wraps at the edges.
        sx  = vx % SCREEN_COLS_DEF;
        sy  = vy % SCREEN_ROWS_DEF;
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          row = ram_img[idx_img + 12'(r)];
          for (int c = 0; c < 8; c++) begin
            pos = ((sy + r) % SCREEN_ROWS_DEF) * SCREEN_COLS_DEF + (sx + c) % SCREEN_COLS_DEF;
            if (row[7 - c]) begin
              if (frame_img[pos]) hit = 1'b1;
              frame_img[pos] = ~frame_img[pos];
            end
          end
        end
        vreg[REG_VF] = {7'd0, hit};
      end
      GRP_KEY: begin
        if (kk != KEY_SKP && kk != KEY_SKNP) return ST_BAD_OP;
      end
      default: begin
        case (kk)
          MISC_GDLY: vreg[x] = delay_img;
          MISC_WKEY: ;
          MISC_SDLY: delay_img = vx;
          MISC_SSND: sound_img = vx;
          MISC_ADDI: idx_img = idx_img + {4'd0, vx};
          MISC_FONT: idx_img = 12'(vx * 5);
          MISC_BCD: begin
            ram_img[idx_img]         = vx / DEC_HUNDRED;
            ram_img[idx_img + 12'd1] = (vx / DEC_TEN) % DEC_TEN;
            ram_img[idx_img + 12'd2] = vx % DEC_TEN;
          end
          MISC_STOR: for (int i = 0; i <= x; i++) ram_img[idx_img + 12'(i)] = vreg[i];
          MISC_LOAD: for (int i = 0; i <= x; i++) vreg[i] = ram_img[idx_img + 12'(i)];
          default: return ST_BAD_OP;
        endcase
      end
    endcase
    return ST_OK;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word, waits for it to be taken and queues the result it must produce.
  task automatic send_word(input logic [1:0] cmd, input logic [11:0] addr,
                           input logic [7:0] wdata, input logic [7:0] rnd);
    int      gap;
    result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command     <= cmd;
    address     <= addr;
    write_data  <= wdata;
    random_byte <= rnd;
    in_valid    <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    res = '0;
    case (cmd)
      CMD_WRITE: ram_img[addr] = wdata;
      CMD_EXEC: begin
        res.status = exec_instruction(rnd);
        exec_count++;
        if (res.status == ST_STACK) stack_faults++;
        if (res.status == ST_BAD_OP) bad_opcodes++;
      end
      CMD_READ: res.value = ram_img[addr];
      default:  res.value = (addr < PIXELS) ? {7'd0, frame_img[addr]} : 8'd0;
    endcase
    res.pc    = pc_img;
    res.sound = sound_img;
    pending_results.push_back(res);
    words_sent++;
  endtask

  // Places an instruction at the program counter and runs it.
  task automatic run_op(input logic [15:0] op);
    send_word(CMD_WRITE, pc_img, op[15:8], 8'($urandom));
    send_word(CMD_WRITE, pc_img + 12'd1, op[7:0], 8'($urandom));
    send_word(CMD_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] op_xkk(input logic [3:0] grp, input logic [3:0] x,
                                         input logic [7:0] kk);
    return {grp, x, kk};
  endfunction

  function automatic logic [15:0] op_xyn(input logic [3:0] grp, input logic [3:0] x,
                                         input logic [3:0] y, input logic [3:0] n);
    return {grp, x, y, n};
  endfunction

  function automatic logic [15:0] op_nnn(input logic [3:0] grp, input logic [11:0] nnn);
    return {grp, nnn};
  endfunction

  // Memory writes and reads and pixel reads at the extremes, font included.
  task automatic test_memory_access();
    send_word(CMD_READ, 12'd0, 8'd0, 8'd0);
    send_word(CMD_READ, 12'd79, 8'd0, 8'd0);
    send_word(CMD_WRITE, 12'hFFF, 8'hFF, 8'hFF);
    send_word(CMD_READ, 12'hFFF, 8'hFF, 8'hFF);
    send_word(CMD_WRITE, 12'h800, 8'h00, 8'h00);
    send_word(CMD_READ, 12'h800, 8'h00, 8'h00);
    send_word(CMD_PIXEL, 12'd0, 8'd0, 8'd0);
    send_word(CMD_PIXEL, 12'd2047, 8'd0, 8'd0);
    send_word(CMD_PIXEL, 12'hFFF, 8'd0, 8'd0);
  endtask

  // Every ALU operation, the equal subtraction carry and VF as destination.
  task automatic test_alu_ops();
    run_op(op_xkk(GRP_LDI, 4'd1, 8'hFF));
    run_op(op_xkk(GRP_LDI, 4'd2, 8'hFF));
    run_op(op_xyn(GRP_ALU, 4'd1, 4'd2, ALU_SUB));
    run_op(op_xyn(GRP_ALU, 4'd1, 4'd2, ALU_SBN));
    run_op(op_xkk(GRP_LDI, 4'd1, 8'h81));
    run_op(op_xyn(GRP_ALU, 4'd1, 4'd2, ALU_ADD));
    run_op(op_xyn(GRP_ALU, 4'd3, 4'd2, ALU_MOV));
    run_op(op_xyn(GRP_ALU, 4'd3, 4'd1, ALU_OR));
    run_op(op_xyn(GRP_ALU, 4'd3, 4'd1, ALU_AND));
    run_op(op_xyn(GRP_ALU, 4'd3, 4'd1, ALU_XOR));
    run_op(op_xyn(GRP_ALU, 4'd2, 4'd0, ALU_SHR));
    run_op(op_xyn(GRP_ALU, 4'd2, 4'd0, ALU_SHL));
    run_op(op_xkk(GRP_LDI, REG_VF, 8'hF0));
    run_op(op_xyn(GRP_ALU, REG_VF, 4'd2, ALU_ADD));
    run_op(op_xyn(GRP_ALU, 4'd1, 4'd2, 4'h8));
    run_op(op_xkk(GRP_ADDI, 4'd1, 8'hFF));
    run_op(op_xkk(GRP_RND, 4'd4, 8'h5A));
  endtask

  // Jumps, skips, calls and returns, including both stack faults.
  task automatic test_control_flow();
    run_op(op_xkk(GRP_SYS, 4'd0, SYS_RET));
    run_op(op_xkk(GRP_SEQI, 4'd1, vreg[1]));
    run_op(op_xkk(GRP_SNEI, 4'd1, vreg[1]));
    run_op(op_xyn(GRP_SEQR, 4'd1, 4'd1, 4'h7));
    run_op(op_xyn(GRP_SNER, 4'd1, 4'd2, 4'h3));
    run_op(op_nnn(GRP_JPV0, 12'hFFF));
    run_op(op_nnn(GRP_JP, 12'h300));
    run_op(op_nnn(GRP_SYS, 12'h123));
    for (int i = 0; i <= STACK_SLOTS_DEF; i++) begin
      run_op(op_nnn(GRP_CALL, 12'h400 + 12'(i * 4)));
    end
    for (int i = 0; i < STACK_SLOTS_DEF; i++) begin
      run_op(op_xkk(GRP_SYS, 4'd0, SYS_RET));
    end
  endtask

  // Screen clear, font sprites with wrap at the corner, and collision.
  task automatic test_display();
    run_op(op_xkk(GRP_LDI, 4'd5, 8'hFE));
    run_op(op_xkk(GRP_LDI, 4'd6, 8'h3E));
    run_op(op_xkk(GRP_MISC, 4'd5, MISC_FONT));
    run_op(op_xkk(GRP_LDI, 4'd7, 8'h08));
    run_op(op_xkk(GRP_MISC, 4'd7, MISC_FONT));
    run_op(op_xyn(GRP_DRW, 4'd5, 4'd6, 4'd15));
    run_op(op_xyn(GRP_DRW, 4'd5, 4'd6, 4'd5));
    send_word(CMD_PIXEL, 12'd1983, 8'd0, 8'd0);
    send_word(CMD_PIXEL, 12'd0, 8'd0, 8'd0);
    run_op(op_xkk(GRP_SYS, 4'd0, SYS_CLS));
    send_word(CMD_PIXEL, 12'd0, 8'd0, 8'd0);
  endtask

  // Timers, index arithmetic, BCD, register dump and load, key and invalid codes.
  task automatic test_misc_group();
    run_op(op_xkk(GRP_LDI, 4'd8, 8'd255));
    run_op(op_xkk(GRP_MISC, 4'd8, MISC_SDLY));
    run_op(op_xkk(GRP_MISC, 4'd8, MISC_SSND));
    run_op(op_xkk(GRP_MISC, 4'd9, MISC_GDLY));
    run_op(op_nnn(GRP_LDIX, 12'hFFE));
    run_op(op_xkk(GRP_MISC, 4'd8, MISC_BCD));
    run_op(op_xkk(GRP_MISC, 4'd8, MISC_ADDI));
    run_op(op_xkk(GRP_MISC, 4'd15, MISC_STOR));
    run_op(op_xkk(GRP_MISC, 4'd15, MISC_LOAD));
    run_op(op_xkk(GRP_MISC, 4'd0, MISC_WKEY));
    run_op(op_xkk(GRP_KEY, 4'd0, KEY_SKP));
    run_op(op_xkk(GRP_KEY, 4'd0, KEY_SKNP));
    run_op(op_xkk(GRP_KEY, 4'd0, 8'h00));
    run_op(op_xkk(GRP_MISC, 4'd0, 8'hFF));
  endtask

  function automatic logic [15:0] random_op();
    logic [3:0]  grp;
    logic [15:0] op;
    logic [7:0]  misc_codes [9];
    misc_codes = '{MISC_GDLY, MISC_WKEY, MISC_SDLY, MISC_SSND, MISC_ADDI,
                   MISC_FONT, MISC_BCD, MISC_STOR, MISC_LOAD};
    grp = 4'($urandom_range(0, 15));
    op  = {grp, 12'($urandom)};
    case (grp)
      GRP_SYS: begin
        // Clears are slow, so they stay rare.
        if ($urandom_range(0, 19) == 0) op[7:0] = SYS_CLS;
        else if ($urandom_range(0, 1) == 0) op[7:0] = SYS_RET;
      end
      GRP_ALU: if ($urandom_range(0, 9) != 0) begin
        op[3:0] = ($urandom_range(0, 8) == 8) ? ALU_SHL : 4'($urandom_range(0, 7));
      end
      GRP_DRW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 4));
      GRP_KEY: if ($urandom_range(0, 3) != 0) begin
        op[7:0] = $urandom_range(0, 1) ? KEY_SKP : KEY_SKNP;
      end
      GRP_MISC: if ($urandom_range(0, 9) != 0) op[7:0] = misc_codes[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  // Random mix of instructions and raw memory and pixel accesses.
  task automatic test_random_mix(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == count / 2) drain();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        run_op(random_op());
        i += 2;
      end else if (kind < 7) begin
        send_word(CMD_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind == 7) begin
        send_word(CMD_WRITE, 12'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind == 8) begin
        send_word(CMD_READ, 12'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_word(CMD_PIXEL, 12'($urandom_range(0, 2100)), 8'($urandom), 8'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_WRITE;
    address     = 12'd0;
    write_data  = 8'd0;
    random_byte = 8'd0;
    no_gaps     = 1'b0;
    reset_image();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_memory_access();
    test_alu_ops();
    test_control_flow();
    test_display();
    test_misc_group();
    test_random_mix(450);
    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d words, %0d of them instructions; checked %0d results.",
             words_sent, exec_count, results_seen);
    $display("Instructions hit %0d stack faults and %0d invalid opcodes.",
             stack_faults, bad_opcodes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The result side: random stalls on ready, and each accepted result is compared
  // field by field with the oldest expected one.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (program_counter !== want.pc) begin
          $error("program_counter: expected %h, got %h", want.pc, program_counter);
          errors++;
        end
        if (read_value !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, read_value);
          errors++;
        end
        if (sound_level !== want.sound) begin
          $error("sound_level: expected %h, got %h", want.sound, sound_level);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
